// ----- rtl/core/ffca_pkg.sv -----
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit contiguous allocator: channel
// payloads, result codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package ffca_pkg;

   // Table and address geometry.
   localparam int MAX_BLOCKS     = 64;
   localparam int ADDR_W         = 32;
   localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W          = $clog2(MAX_BLOCKS);
   localparam int ENTRY_W        = 2 * ADDR_W;
   localparam int LOG_W          = 5;
   localparam int MIN_ALIGN_LOG2 = 12;
   localparam int CSR_IDX_W      = 1;
   localparam int STATUS_W       = 3;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK              = 3'd0,
      STAT_OUT_OF_REGION   = 3'd1,
      STAT_TABLE_FULL      = 3'd2,
      STAT_NOT_ALLOCATED   = 3'd3,
      STAT_NOT_BLOCK_START = 3'd4
   } status_code_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE  = 1'd0,
      CSR_REGION_LIMIT = 1'd1
   } csr_index_type;

   // Input item.
   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] request_size;
      logic [LOG_W-1:0]  align_log2;
      logic [ADDR_W-1:0] address;
   } req_payload_type;

   // Result item.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   block_address;
      logic                found;
      logic [ADDR_W-1:0]   remaining_bytes;
   } rsp_payload_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_ALLOC_EV,
      S_ALLOC_LAST,
      S_PLACE,
      S_MOVE_TEST,
      S_MOVE_RD,
      S_MOVE_WR,
      S_INSERT,
      S_FIND_EV,
      S_FIND_END,
      S_REM_TEST,
      S_REM_RD,
      S_REM_WR,
      S_REM_DONE,
      S_PUSH
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ALLOC_EMPTY,
      OP_SCAN_RD,
      OP_ALLOC_EV,
      OP_ALLOC_LAST,
      OP_PLACE,
      OP_MOVE_RD,
      OP_MOVE_WR,
      OP_INSERT,
      OP_FIND_EV,
      OP_FIND_END,
      OP_REM_RD,
      OP_REM_WR,
      OP_REM_DONE,
      OP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic is_find;
      logic zero_size;
      logic cnt_zero;
      logic last_entry;
      logic gap_fit;
      logic find_hit;
      logic place_fail;
      logic remove;
      logic move_more;
      logic rem_more;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/core/first_fit_contiguous_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator_unit
// First-fit allocator over an address-sorted table of up to 64 blocks,
// serving allocate, free and query requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Beat
//  req_      in         req_valid/stall    one request
//  rsp_      out        rsp_valid/stall    one result
//  csr_      in         csr_valid/ready    one register write
//
// A request reads each table entry that it scans through the table memory's
// one registered read port, and tests, reads and writes each entry that is
// shifted on an insert or a removal.
// Reset is synchronous and leaves the table empty; no clearing pass is needed.
// A finished result waits in an output register while the next request is
// taken; a new result is only held back while that register stays stalled.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ffca_pkg::req_payload_type       req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ffca_pkg::rsp_payload_type       rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffca_pkg::ADDR_W-1:0]     csr_wdata
);
   import ffca_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The user is to issue register writes only while no request is in flight;
   // the block itself does not enforce this. The port is always ready.
   assign csr_ready = 1'b1;

   ffca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   ffca_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule

// ----- rtl/core/ffca_ram.sv -----
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/ffca_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for the allocator: walks the block table for each request and
// tells the datapath what to do in every cycle.
// ----------------------------------------------------------------------------
module ffca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffca_pkg::dp_status_type dp_status,
   output ffca_pkg::dp_cmd_type    dp_cmd
);
   import ffca_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (dp_status.is_alloc) begin
               state_in = (dp_status.zero_size || dp_status.cnt_zero) ? S_PLACE : S_SCAN_RD;
            end else if (dp_status.is_find) begin
               state_in = dp_status.cnt_zero ? S_FIND_END : S_SCAN_RD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_SCAN_RD: begin
            state_in = dp_status.is_alloc ? S_ALLOC_EV : S_FIND_EV;
         end
         S_ALLOC_EV: begin
            if (dp_status.gap_fit) state_in = S_PLACE;
            else if (dp_status.last_entry) state_in = S_ALLOC_LAST;
            else state_in = S_SCAN_RD;
         end
         S_ALLOC_LAST: state_in = S_PLACE;
         S_PLACE: begin
            state_in = dp_status.place_fail ? S_PUSH : S_MOVE_TEST;
         end
         S_MOVE_TEST: begin
            state_in = dp_status.move_more ? S_MOVE_RD : S_INSERT;
         end
         S_MOVE_RD: state_in = S_MOVE_WR;
         S_MOVE_WR: state_in = S_MOVE_TEST;
         S_INSERT:  state_in = S_PUSH;
         S_FIND_EV: begin
            if (dp_status.find_hit || dp_status.last_entry) state_in = S_FIND_END;
            else state_in = S_SCAN_RD;
         end
         S_FIND_END: begin
            state_in = dp_status.remove ? S_REM_TEST : S_PUSH;
         end
         S_REM_TEST: begin
            state_in = dp_status.rem_more ? S_REM_RD : S_REM_DONE;
         end
         S_REM_RD:   state_in = S_REM_WR;
         S_REM_WR:   state_in = S_REM_TEST;
         S_REM_DONE: state_in = S_PUSH;
         S_PUSH: begin
            if (dp_status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      dp_cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:       dp_cmd.op = req_valid ? OP_LOAD : OP_NONE;
         S_DISPATCH:   dp_cmd.op = OP_ALLOC_EMPTY;
         S_SCAN_RD:    dp_cmd.op = OP_SCAN_RD;
         S_ALLOC_EV:   dp_cmd.op = OP_ALLOC_EV;
         S_ALLOC_LAST: dp_cmd.op = OP_ALLOC_LAST;
         S_PLACE:      dp_cmd.op = OP_PLACE;
         S_MOVE_RD:    dp_cmd.op = OP_MOVE_RD;
         S_MOVE_WR:    dp_cmd.op = OP_MOVE_WR;
         S_INSERT:     dp_cmd.op = OP_INSERT;
         S_FIND_EV:    dp_cmd.op = OP_FIND_EV;
         S_FIND_END:   dp_cmd.op = OP_FIND_END;
         S_REM_RD:     dp_cmd.op = OP_REM_RD;
         S_REM_WR:     dp_cmd.op = OP_REM_WR;
         S_REM_DONE:   dp_cmd.op = OP_REM_DONE;
         S_PUSH:       dp_cmd.op = dp_status.out_free ? OP_PUSH : OP_NONE;
         default:      dp_cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- rtl/core/ffca_dp.sv -----
// ----------------------------------------------------------------------------
// ffca_dp
// Datapath for the allocator: block table memory, request and scan
// registers, gap and lookup arithmetic, configuration and result registers.
// ----------------------------------------------------------------------------
module ffca_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ffca_pkg::req_payload_type           req_payload,
   input  logic                                csr_write,
   input  logic [ffca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffca_pkg::ADDR_W-1:0]         csr_wdata,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output ffca_pkg::rsp_payload_type           rsp_payload,
   input  ffca_pkg::dp_cmd_type                dp_cmd,
   output ffca_pkg::dp_status_type             dp_status
);
   import ffca_pkg::*;

   // Control registers.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] limit_ff, limit_in;

   // Payload registers.
   logic [1:0]            kind_ff, kind_in;
   logic [ADDR_W-1:0]     size_ff, size_in;
   logic [ADDR_W-1:0]     mask_ff, mask_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ADDR_W-1:0]     prev_start_ff, prev_start_in;
   logic [ADDR_W-1:0]     prev_size_ff, prev_size_in;
   logic [ADDR_W-1:0]     cand_ff, cand_in;
   logic                  cand_ok_ff, cand_ok_in;
   logic [ADDR_W-1:0]     place_ff, place_in;
   logic                  place_ok_ff, place_ok_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic                  hit_ff, hit_in;
   rsp_payload_type       res_ff, res_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // Memory ports.
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [CNT_W-1:0]   rd_idx;

   // Arithmetic.
   logic [LOG_W-1:0]  lg_eff;
   logic [ADDR_W-1:0] mask_new;
   logic [ADDR_W:0]   prev_end;
   logic [ADDR_W:0]   prev_sum;
   logic [ADDR_W-1:0] cand_c;
   logic              cand_ok_c;
   logic [ADDR_W:0]   base_sum;
   logic [ADDR_W-1:0] cur_start;
   logic [ADDR_W-1:0] cur_size;
   logic [ADDR_W:0]   fit;
   logic              gap_fit_c;
   logic              hit_c;
   logic [ADDR_W:0]   place_end;
   logic              fail_region;
   logic              full_c;
   logic              remove_c;

   ffca_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Alignment mask, with small alignments raised to the minimum page.
   assign lg_eff   = (req_payload.align_log2 < LOG_W'(MIN_ALIGN_LOG2)) ?
                     LOG_W'(MIN_ALIGN_LOG2) : req_payload.align_log2;
   assign mask_new = (ADDR_W'(1) << lg_eff) - ADDR_W'(1);

   // Aligned end of the previous block; a carry out means no candidate.
   assign prev_end  = {1'b0, prev_start_ff} + {1'b0, prev_size_ff};
   assign prev_sum  = {1'b0, prev_end[ADDR_W-1:0]} + {1'b0, mask_ff};
   assign cand_c    = prev_sum[ADDR_W-1:0] & ~mask_ff;
   assign cand_ok_c = !prev_end[ADDR_W] && !prev_sum[ADDR_W];
   assign base_sum  = {1'b0, base_ff} + {1'b0, mask_ff};

   // Current table entry and the strict gap test against it.
   assign cur_start = rd_data[ENTRY_W-1:ADDR_W];
   assign cur_size  = rd_data[ADDR_W-1:0];
   assign fit       = {1'b0, cand_ff} + {1'b0, size_ff};
   assign gap_fit_c = (idx_ff != '0) && cand_ok_ff && (cand_ff < cur_start) &&
                      !fit[ADDR_W] && (fit[ADDR_W-1:0] < cur_start);
   assign hit_c     = (cur_start <= addr_ff) && ((addr_ff - cur_start) < cur_size);

   // Final placement checks.
   assign place_end   = {1'b0, place_ff} + {1'b0, size_ff};
   assign fail_region = !place_ok_ff || place_end[ADDR_W] ||
                        (place_end[ADDR_W-1:0] > limit_ff);
   assign full_c      = (cnt_ff == CNT_W'(MAX_BLOCKS));
   assign remove_c    = hit_ff && (kind_ff == KIND_FREE) && (prev_start_ff == addr_ff);

   // Memory addressing.
   always_comb begin
      case (dp_cmd.op)
         OP_MOVE_RD: rd_idx = idx_ff - CNT_W'(1);
         OP_REM_RD:  rd_idx = idx_ff + CNT_W'(1);
         default:    rd_idx = idx_ff;
      endcase
      rd_addr = rd_idx[IDX_W-1:0];
      rd_en   = (dp_cmd.op == OP_SCAN_RD) || (dp_cmd.op == OP_MOVE_RD) ||
                (dp_cmd.op == OP_REM_RD);
      wr_en   = (dp_cmd.op == OP_MOVE_WR) || (dp_cmd.op == OP_REM_WR) ||
                (dp_cmd.op == OP_INSERT);
      if (dp_cmd.op == OP_INSERT) begin
         wr_addr = pos_ff[IDX_W-1:0];
         wr_data = {place_ff, size_ff};
      end else begin
         wr_addr = idx_ff[IDX_W-1:0];
         wr_data = rd_data;
      end
   end

   // Next values of all registers.
   always_comb begin
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      mask_in       = mask_ff;
      addr_in       = addr_ff;
      prev_start_in = prev_start_ff;
      prev_size_in  = prev_size_ff;
      cand_in       = cand_ff;
      cand_ok_in    = cand_ok_ff;
      place_in      = place_ff;
      place_ok_in   = place_ok_ff;
      pos_in        = pos_ff;
      hit_in        = hit_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;

      // The result slot empties once its beat is taken.
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_REGION_BASE:  base_in  = csr_wdata;
            CSR_REGION_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (dp_cmd.op)
         OP_LOAD: begin
            kind_in     = req_payload.kind;
            size_in     = req_payload.request_size;
            mask_in     = mask_new;
            addr_in     = req_payload.address;
            idx_in      = '0;
            place_ok_in = 1'b0;
            hit_in      = 1'b0;
            res_in      = '0;
         end
         OP_ALLOC_EMPTY: begin
            if ((kind_ff == KIND_ALLOC) && (cnt_ff == '0) && (size_ff != '0)) begin
               place_in    = base_sum[ADDR_W-1:0] & ~mask_ff;
               place_ok_in = !base_sum[ADDR_W];
               pos_in      = '0;
            end
         end
         OP_SCAN_RD: begin
            cand_in    = cand_c;
            cand_ok_in = cand_ok_c;
         end
         OP_ALLOC_EV: begin
            if (gap_fit_c) begin
               place_in    = cand_ff;
               place_ok_in = 1'b1;
               pos_in      = idx_ff;
            end
            prev_start_in = cur_start;
            prev_size_in  = cur_size;
            idx_in        = idx_ff + CNT_W'(1);
         end
         OP_ALLOC_LAST: begin
            place_in    = cand_c;
            place_ok_in = cand_ok_c;
            pos_in      = cnt_ff;
         end
         OP_PLACE: begin
            if (fail_region) begin
               res_in.status = STAT_OUT_OF_REGION;
            end else if (full_c) begin
               res_in.status = STAT_TABLE_FULL;
            end else begin
               res_in.status        = STAT_OK;
               res_in.block_address = place_ff;
            end
            idx_in = cnt_ff;
         end
         OP_MOVE_WR: idx_in = idx_ff - CNT_W'(1);
         OP_INSERT:  cnt_in = cnt_ff + CNT_W'(1);
         OP_FIND_EV: begin
            prev_start_in = cur_start;
            prev_size_in  = cur_size;
            hit_in        = hit_c;
            if (!hit_c) idx_in = idx_ff + CNT_W'(1);
         end
         OP_FIND_END: begin
            if (!hit_ff) begin
               res_in.status = STAT_NOT_ALLOCATED;
            end else if (kind_ff == KIND_QUERY) begin
               res_in.block_address   = prev_start_ff;
               res_in.found           = 1'b1;
               res_in.remaining_bytes = prev_size_ff - (addr_ff - prev_start_ff);
            end else if (prev_start_ff != addr_ff) begin
               res_in.status = STAT_NOT_BLOCK_START;
            end else begin
               res_in.block_address = addr_ff;
            end
         end
         OP_REM_WR:   idx_in = idx_ff + CNT_W'(1);
         OP_REM_DONE: cnt_in = cnt_ff - CNT_W'(1);
         OP_PUSH: begin
            rsp_in       = res_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         limit_ff     <= '1;
      end else begin
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      mask_ff       <= mask_in;
      addr_ff       <= addr_in;
      prev_start_ff <= prev_start_in;
      prev_size_ff  <= prev_size_in;
      cand_ff       <= cand_in;
      cand_ok_ff    <= cand_ok_in;
      place_ff      <= place_in;
      place_ok_ff   <= place_ok_in;
      pos_ff        <= pos_in;
      hit_ff        <= hit_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   // Status toward the controller.
   always_comb begin
      dp_status.is_alloc   = (kind_ff == KIND_ALLOC);
      dp_status.is_find    = (kind_ff == KIND_FREE) || (kind_ff == KIND_QUERY);
      dp_status.zero_size  = (size_ff == '0);
      dp_status.cnt_zero   = (cnt_ff == '0);
      dp_status.last_entry = ((idx_ff + CNT_W'(1)) == cnt_ff);
      dp_status.gap_fit    = gap_fit_c;
      dp_status.find_hit   = hit_c;
      dp_status.place_fail = fail_region || full_c;
      dp_status.remove     = remove_c;
      dp_status.move_more  = (idx_ff > pos_ff);
      dp_status.rem_more   = ((idx_ff + CNT_W'(1)) < cnt_ff);
      dp_status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- tb/sv/tb_first_fit_contiguous_allocator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_contiguous_allocator_unit
// Drives allocate, free and query beats into the allocator and checks each
// result beat against an in-bench first-fit table model. Random gaps on the
// request side and random stalls on the result side cover handshake timing.
// The run passes through several base and limit settings, extremes included.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_allocator_unit;
   import ffca_pkg::*;

   localparam longint unsigned ADDR_MAX   = 64'hFFFF_FFFF;
   localparam int              CYCLE_LIMIT = 4_000_000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_wdata = '0;

   first_fit_contiguous_allocator_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock: 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of the block table and the region registers.
   logic [ADDR_W-1:0] tbl_start [MAX_BLOCKS];
   logic [ADDR_W-1:0] tbl_size  [MAX_BLOCKS];
   int                tbl_count = 0;
   logic [ADDR_W-1:0] base_reg  = '0;
   logic [ADDR_W-1:0] limit_reg = '1;

   req_payload_type pending_reqs [$];
   rsp_payload_type expected_rsps [$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;
   bit  req_fire = 1'b0;
   int  req_gap = 0;
   int  stall_left = 0;

   // Sum within the 32-bit address space; returns 0 on overflow.
   function automatic bit addr_add(input longint unsigned a, input longint unsigned b,
                                   output longint unsigned s);
      s = a + b;
      return s <= ADDR_MAX;
   endfunction

   // Index of the block holding an address, or -1.
   function automatic int lookup_block(input logic [ADDR_W-1:0] a);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_start[i] <= a && a - tbl_start[i] < tbl_size[i]) return i;
      end
      return -1;
   endfunction

   // First-fit placement; updates the table on success.
   function automatic rsp_payload_type alloc_block(input logic [ADDR_W-1:0] size,
                                                   input logic [LOG_W-1:0] lg_in);
      rsp_payload_type r;
      longint unsigned mask, addr, e, cand, fit, fin;
      int  lg, pos;
      bit  ok;
      r = '0;
      addr = 0;
      pos = 0;
      ok = 1'b0;
      lg = (lg_in < MIN_ALIGN_LOG2) ? MIN_ALIGN_LOG2 : lg_in;
      mask = (64'd1 << lg) - 1;
      if (size == 0) begin
         r.status = STAT_OUT_OF_REGION;
         return r;
      end
      if (tbl_count == 0) begin
         ok = addr_add(base_reg, mask, addr);
         addr = addr & ~mask;
      end else begin
         for (int i = 0; i < tbl_count; i++) begin
            if (!addr_add(tbl_start[i], tbl_size[i], e) || !addr_add(e, mask, cand)) begin
               if (i + 1 >= tbl_count) break;
               continue;
            end
            cand = cand & ~mask;
            if (i + 1 >= tbl_count) begin
               addr = cand; pos = tbl_count; ok = 1'b1;
               break;
            end
            if (cand < tbl_start[i+1] && addr_add(cand, size, fit) && fit < tbl_start[i+1]) begin
               addr = cand; pos = i + 1; ok = 1'b1;
               break;
            end
         end
      end
      if (!ok || !addr_add(addr, size, fin) || fin > limit_reg) begin
         r.status = STAT_OUT_OF_REGION;
         return r;
      end
      if (tbl_count >= MAX_BLOCKS) begin
         r.status = STAT_TABLE_FULL;
         return r;
      end
      for (int i = tbl_count; i > pos; i--) begin
         tbl_start[i] = tbl_start[i-1];
         tbl_size[i]  = tbl_size[i-1];
      end
      tbl_start[pos] = addr[ADDR_W-1:0];
      tbl_size[pos]  = size;
      tbl_count++;
      r.status = STAT_OK;
      r.block_address = addr[ADDR_W-1:0];
      return r;
   endfunction

   // Expected result of one request beat.
   function automatic rsp_payload_type predict_result(input req_payload_type q);
      rsp_payload_type r;
      int idx;
      r = '0;
      case (q.kind)
         KIND_ALLOC: r = alloc_block(q.request_size, q.align_log2);
         KIND_FREE: begin
            idx = lookup_block(q.address);
            if (idx < 0) r.status = STAT_NOT_ALLOCATED;
            else if (tbl_start[idx] != q.address) r.status = STAT_NOT_BLOCK_START;
            else begin
               for (int i = idx; i + 1 < tbl_count; i++) begin
                  tbl_start[i] = tbl_start[i+1];
                  tbl_size[i]  = tbl_size[i+1];
               end
               tbl_count--;
               r.block_address = q.address;
            end
         end
         KIND_QUERY: begin
            idx = lookup_block(q.address);
            if (idx < 0) r.status = STAT_NOT_ALLOCATED;
            else begin
               r.block_address   = tbl_start[idx];
               r.found           = 1'b1;
               r.remaining_bytes = tbl_size[idx] - (q.address - tbl_start[idx]);
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic issue(input req_payload_type q);
      expected_rsps.push_back(predict_result(q));
      pending_reqs.push_back(q);
   endtask

   function automatic req_payload_type mk_req(input kind_type k, input logic [31:0] size,
                                              input logic [4:0] lg, input logic [31:0] a);
      req_payload_type q;
      q.kind = k;
      q.request_size = size;
      q.align_log2 = lg;
      q.address = a;
      return q;
   endfunction

   // One random request; alloc_pct biases toward growing the table.
   task automatic random_req(input int alloc_pct);
      req_payload_type q;
      int sel, pick, idx;
      q = mk_req(KIND_NONE, $urandom, 5'($urandom_range(0, 31)), $urandom);
      sel = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
      if (sel < alloc_pct) begin
         q.kind = KIND_ALLOC;
         if (pick < 7) q.request_size = $urandom_range(1, 32'h3000);
         else if (pick == 7) q.request_size = 0;
         if (pick < 8) q.align_log2 = 5'($urandom_range(12, 14));
      end else if (sel < alloc_pct + (100 - alloc_pct) / 2 - 2) begin
         q.kind = KIND_FREE;
         if (tbl_count > 0 && pick < 7) q.address = tbl_start[idx];
         else if (tbl_count > 0 && pick < 9)
            q.address = tbl_start[idx] + $urandom_range(0, tbl_size[idx]);
      end else if (sel < 97) begin
         q.kind = KIND_QUERY;
         if (tbl_count > 0 && pick < 8)
            q.address = tbl_start[idx] + $urandom_range(0, tbl_size[idx]);
      end
      issue(q);
   endtask

   // Wait until every request is taken and every result has come back.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_REGION_BASE) base_reg = value;
      else limit_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [31:0] b, input logic [31:0] l,
                            input int n, input int alloc_pct, input bit no_idle);
      drain();
      csr_write(CSR_REGION_BASE, b);
      csr_write(CSR_REGION_LIMIT, l);
      quiet = no_idle;
      for (int i = 0; i < n; i++) random_req(alloc_pct);
   endtask

   // Request driver: loads beats at the falling edge, with random gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_fire) begin
            req_gap = quiet ? 0 : $urandom_range(0, 7);
            if (req_gap == 0 && pending_reqs.size() != 0) begin
               req_payload <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() != 0) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Result stall: each result beat waits a random number of cycles.
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: checks result beats at the rising edge.
   always @(posedge clock) begin
      rsp_payload_type want;
      req_fire <= req_valid && !req_stall;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = quiet ? 0 : $urandom_range(0, 7);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", rsp_payload);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.block_address !== want.block_address ||
                rsp_payload.found !== want.found ||
                rsp_payload.remaining_bytes !== want.remaining_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_first_fit_contiguous_allocator_unit: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero address, size zero, overflow, bad frees, unused kind.
      issue(mk_req(KIND_ALLOC, 32'd1, 5'd0, 32'd0));
      issue(mk_req(KIND_QUERY, 32'd0, 5'd0, 32'd0));
      issue(mk_req(KIND_QUERY, 32'd0, 5'd0, 32'd1));
      issue(mk_req(KIND_ALLOC, 32'd0, 5'd12, 32'd0));
      issue(mk_req(KIND_ALLOC, 32'hFFFF_FFFF, 5'd31, 32'd0));
      issue(mk_req(KIND_ALLOC, 32'h1000, 5'd12, 32'd0));
      issue(mk_req(KIND_FREE, 32'd0, 5'd0, 32'h1004));
      issue(mk_req(KIND_FREE, 32'd0, 5'd0, 32'h5000));
      issue(mk_req(KIND_QUERY, 32'd0, 5'd0, 32'h1FFF));
      issue(mk_req(KIND_ALLOC, 32'h8000_0000, 5'd31, 32'd0));
      issue(mk_req(KIND_ALLOC, 32'h7FFF_FFFF, 5'd31, 32'd0));
      issue(mk_req(KIND_QUERY, 32'd0, 5'd0, 32'hFFFF_FFFF));
      issue(mk_req(KIND_ALLOC, 32'h10, 5'd12, 32'd0));
      issue(mk_req(KIND_FREE, 32'd0, 5'd0, 32'h1000));
      issue(mk_req(KIND_ALLOC, 32'h800, 5'd12, 32'd0));
      issue(mk_req(KIND_NONE, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF));
      issue(mk_req(KIND_FREE, 32'd0, 5'd0, 32'd0));
      issue(mk_req(KIND_QUERY, 32'd0, 5'd0, 32'h0000_0FFF));

      // The sender holds off here until the block is idle.
      run_phase(32'h0, 32'hFFFF_FFFF, 250, 80, 1'b0);
      run_phase($urandom, 32'hFFFF_FFFF, 200, 45, 1'b1);
      run_phase(32'h0001_0000, 32'h0008_0000, 200, 60, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'h0, 100, 40, 1'b0);
      run_phase($urandom_range(0, 32'h10_0000), $urandom, 200, 55, 1'b0);
      run_phase(32'h0, 32'hFFFF_FFFF, 250, 20, 1'b0);
      drain();
      repeat (20) @(negedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("tb_first_fit_contiguous_allocator_unit: PASS");
      end else begin
         $display("tb_first_fit_contiguous_allocator_unit: FAIL");
      end
      $finish;
   end

endmodule
